// ===== rtl/pfa_pkg.sv =====
// pfa_pkg: shared types and constants of the page frame allocator
// status codes, bitmap word geometry, reset base address, encoder result type
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    localparam logic [31:0] BASE_RESET = 32'h0400_0000;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_OOM    = 3'd1;
    localparam logic [2:0] ST_ABOVE  = 3'd2;
    localparam logic [2:0] ST_DOUBLE = 3'd3;
    localparam logic [2:0] ST_BELOW  = 3'd4;

    typedef struct packed {
        logic                  found;
        logic [WORD_SHIFT-1:0] pos;
    } lz_res_t;

endpackage

// ===== rtl/pfa_ram.sv =====
// pfa_ram: generic simple dual port RAM, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 768,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pfa_lzero.sv =====
// pfa_lzero: shared lowest-zero-bit finder over one 64-bit bitmap word
// depends on pfa_pkg
`timescale 1ns / 1ps

module pfa_lzero (
    input  logic [pfa_pkg::WORD_BITS-1:0] word,
    output pfa_pkg::lz_res_t              res
);

    always_comb begin
        res.found = 1'b0;
        res.pos   = '0;
        for (int i = pfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                res.found = 1'b1;
                res.pos   = pfa_pkg::WORD_SHIFT'(i);
            end
        end
    end

endmodule

// ===== rtl/page_frame_allocator_top.sv =====
// page_frame_allocator_top: first-fit page frame allocator, sequencer and datapath
// depends on pfa_pkg, pfa_ram, pfa_lzero
`timescale 1ns / 1ps

// First-fit page frame allocator over NUM_PAGES pages of 2**PAGE_SHIFT bytes starting at
// memory_base (written on the cfg channel, cfg_ready always high). Used marks live in a bitmap
// RAM of 64-bit words, with a summary RAM holding one full mark per bitmap word; one priority
// encoder serves both levels. An allocate reads and checks summary words in turn (k of them,
// 1 up to ceil(NUM_PAGES/4096)) until one shows a word not full, then reads, checks and commits
// that bitmap word, ending early when no page is free; a free subtracts the base, checks the
// range, then reads, checks and commits the bitmap word, ending early if the address is out of
// range or already free. A result waits while the previous is held by m_ready low; s_ready stays
// low until it is handed over. Reads use each RAM's one registered read port. After reset a
// clearing pass over ceil(NUM_PAGES/64) bitmap words zeroes both RAMs, with s_ready low.
module page_frame_allocator_top #(
    parameter int NUM_PAGES  = 49152,
    parameter int PAGE_SHIFT = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_free_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_page_address,
    output logic [2:0]  m_status
);

    localparam int WB        = pfa_pkg::WORD_BITS;
    localparam int WS        = pfa_pkg::WORD_SHIFT;
    localparam int MAP_WORDS = (NUM_PAGES + WB - 1) / WB;
    localparam int SUM_WORDS = (MAP_WORDS + WB - 1) / WB;
    localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int WIW       = SUM_AW + WS;
    localparam int IW        = WIW + WS;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SUM_RD  = 4'd2;
    localparam logic [3:0] S_SUM_CHK = 4'd3;
    localparam logic [3:0] S_MAP_RD  = 4'd4;
    localparam logic [3:0] S_MAP_CHK = 4'd5;
    localparam logic [3:0] S_COMMIT  = 4'd6;
    localparam logic [3:0] S_F_SUB   = 4'd7;
    localparam logic [3:0] S_F_RANGE = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [31:0]       base_reg;
    logic              mode_reg, mode_next;
    logic [31:0]       addr_reg, addr_next;
    logic [31:0]       diff_reg, diff_next;
    logic [SUM_AW-1:0] sum_ptr_reg, sum_ptr_next;
    logic [WIW-1:0]    word_idx_reg, word_idx_next;
    logic [WS-1:0]     bit_pos_reg, bit_pos_next;
    logic [IW-1:0]     page_idx_reg, page_idx_next;
    logic [WB-1:0]     new_word_reg, new_word_next;
    logic [31:0]       res_addr_reg, res_addr_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [MAP_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_addr_reg, m_addr_next;
    logic [2:0]        m_status_reg, m_status_next;

    logic              map_we, sum_we;
    logic [MAP_AW-1:0] map_waddr;
    logic [SUM_AW-1:0] sum_waddr;
    logic [WB-1:0]     map_wdata, sum_wdata;
    logic [WB-1:0]     map_rdata, sum_rdata;
    logic [WB-1:0]     lz_word;
    pfa_pkg::lz_res_t  lz;

    logic [WIW:0]      cand_word;
    logic [IW:0]       cand_page;
    logic [63:0]       full_addr;
    logic [32:0]       diff_ext;
    logic [32:0]       idx_ext;

    pfa_ram #(.WIDTH(WB), .DEPTH(MAP_WORDS)) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (word_idx_reg[MAP_AW-1:0]),
        .rdata (map_rdata)
    );

    pfa_ram #(.WIDTH(WB), .DEPTH(SUM_WORDS)) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_ptr_reg),
        .rdata (sum_rdata)
    );

    pfa_lzero u_lzero (
        .word (lz_word),
        .res  (lz)
    );

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_page_address = m_addr_reg;
    assign m_status       = m_status_reg;

    assign lz_word   = (state_reg == S_SUM_CHK) ? sum_rdata : map_rdata;
    assign cand_word = {1'b0, sum_ptr_reg, lz.pos};
    assign cand_page = {1'b0, word_idx_reg, lz.pos};
    assign full_addr = 64'(base_reg) + (64'(page_idx_reg) << PAGE_SHIFT);
    assign diff_ext  = {1'b0, addr_reg} - {1'b0, base_reg};
    assign idx_ext   = 33'(diff_reg >> PAGE_SHIFT);

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        diff_next       = diff_reg;
        sum_ptr_next    = sum_ptr_reg;
        word_idx_next   = word_idx_reg;
        bit_pos_next    = bit_pos_reg;
        page_idx_next   = page_idx_reg;
        new_word_next   = new_word_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        clr_cnt_next    = clr_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_addr_next     = m_addr_reg;
        m_status_next   = m_status_reg;

        map_we    = 1'b0;
        sum_we    = 1'b0;
        map_waddr = word_idx_reg[MAP_AW-1:0];
        sum_waddr = sum_ptr_reg;
        map_wdata = new_word_reg;
        sum_wdata = sum_rdata;
        sum_wdata[word_idx_reg[WS-1:0]] = &new_word_reg;

        case (state_reg)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = clr_cnt_reg;
                map_wdata = '0;
                sum_we    = ({1'b0, clr_cnt_reg} < (MAP_AW + 1)'(SUM_WORDS));
                sum_waddr = clr_cnt_reg[SUM_AW-1:0];
                sum_wdata = '0;
                if (clr_cnt_reg == MAP_AW'(MAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    mode_next     = s_mode;
                    addr_next     = s_free_address;
                    res_addr_next = '0;
                    if (s_mode) begin
                        state_next = S_F_SUB;
                    end else begin
                        sum_ptr_next = '0;
                        state_next   = S_SUM_RD;
                    end
                end
            end
            S_SUM_RD: begin
                state_next = S_SUM_CHK;
            end
            S_SUM_CHK: begin
                if (lz.found) begin
                    if (cand_word >= (WIW + 1)'(MAP_WORDS)) begin
                        res_status_next = pfa_pkg::ST_OOM;
                        state_next      = S_DONE;
                    end else begin
                        word_idx_next = cand_word[WIW-1:0];
                        state_next    = S_MAP_RD;
                    end
                end else if (sum_ptr_reg == SUM_AW'(SUM_WORDS - 1)) begin
                    res_status_next = pfa_pkg::ST_OOM;
                    state_next      = S_DONE;
                end else begin
                    sum_ptr_next = sum_ptr_reg + 1'b1;
                    state_next   = S_SUM_RD;
                end
            end
            S_MAP_RD: begin
                state_next = S_MAP_CHK;
            end
            S_MAP_CHK: begin
                if (!mode_reg) begin
                    if (!lz.found || cand_page >= (IW + 1)'(NUM_PAGES)) begin
                        res_status_next = pfa_pkg::ST_OOM;
                        state_next      = S_DONE;
                    end else begin
                        page_idx_next = cand_page[IW-1:0];
                        new_word_next = map_rdata | (WB'(1) << lz.pos);
                        state_next    = S_COMMIT;
                    end
                end else if (map_rdata[bit_pos_reg]) begin
                    new_word_next = map_rdata & ~(WB'(1) << bit_pos_reg);
                    state_next    = S_COMMIT;
                end else begin
                    res_status_next = pfa_pkg::ST_DOUBLE;
                    state_next      = S_DONE;
                end
            end
            S_COMMIT: begin
                state_next = S_DONE;
                if (!mode_reg && (full_addr[63:32] != 32'd0)) begin
                    res_status_next = pfa_pkg::ST_OOM;
                end else begin
                    map_we          = 1'b1;
                    sum_we          = 1'b1;
                    res_status_next = pfa_pkg::ST_OK;
                    if (!mode_reg) begin
                        res_addr_next = full_addr[31:0];
                    end
                end
            end
            S_F_SUB: begin
                if (diff_ext[32]) begin
                    res_status_next = pfa_pkg::ST_BELOW;
                    state_next      = S_DONE;
                end else begin
                    diff_next  = diff_ext[31:0];
                    state_next = S_F_RANGE;
                end
            end
            S_F_RANGE: begin
                if (idx_ext >= 33'(NUM_PAGES)) begin
                    res_status_next = pfa_pkg::ST_ABOVE;
                    state_next      = S_DONE;
                end else begin
                    word_idx_next = idx_ext[WIW+WS-1:WS];
                    bit_pos_next  = idx_ext[WS-1:0];
                    sum_ptr_next  = idx_ext[WIW+WS-1:2*WS];
                    state_next    = S_MAP_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            base_reg    <= pfa_pkg::BASE_RESET;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        diff_reg       <= diff_next;
        sum_ptr_reg    <= sum_ptr_next;
        word_idx_reg   <= word_idx_next;
        bit_pos_reg    <= bit_pos_next;
        page_idx_reg   <= page_idx_next;
        new_word_reg   <= new_word_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
    end

endmodule

// ===== rtl/pfa_checker.sv =====
// pfa_checker: port-level assertions for page_frame_allocator_top, with bind
// depends on pfa_pkg
`timescale 1ns / 1ps

module pfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_page_address,
    input logic [2:0]  m_status
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_page_address) && $stable(m_status))
        else $error("result changed while stalled");

    a_fail_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != pfa_pkg::ST_OK) |-> m_page_address == 32'd0)
        else $error("nonzero address on failed transaction");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= pfa_pkg::ST_BELOW)
        else $error("status code out of range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after an accepted transaction");

    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready during clearing pass");

endmodule

bind page_frame_allocator_top pfa_checker u_pfa_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_page_address (m_page_address),
    .m_status       (m_status)
);
